// ===== hdl/assert_macros.svh =====
// Concurrent assertion helpers, sampled on the rising clock edge and
// disabled while reset is active.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define DTQ_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

`define DTQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dtq_pkg.sv =====
package dtq_pkg;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_DEL  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_BADTIME = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_DELETED = 3'd3;
  localparam logic [2:0] ST_NOTPEND = 3'd4;
  localparam logic [2:0] ST_FIRED   = 3'd5;
  localparam logic [2:0] ST_NONE    = 3'd6;

  localparam logic [31:0] NEAR_EMPTY = 32'hFFFF_FFFF;
  localparam logic [31:0] NEAR_MAX   = 32'hFFFF_FFFE;

  typedef enum logic [1:0] {
    SLOT_ZERO,
    SLOT_FREE,
    SLOT_HANDLE,
    SLOT_PICK
  } slot_sel_e;

  typedef struct packed {
    logic       take_in;
    logic       tick;
    logic       scan_start;
    logic       add_write;
    logic       del_clear;
    logic       fire_clear;
    logic       set_res;
    logic [2:0] res_status;
    slot_sel_e  res_slot;
    logic       res_pick_last;
    logic       calc_near;
    logic       load_fires;
    logic       emit;
  } dtq_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       bad_time;
    logic       hdl_pending;
    logic       scan_done;
    logic       free_found;
    logic       due_any;
    logic       fires_left;
    logic       out_free;
  } dtq_stat_t;

endpackage

// ===== hdl/deadline_timer_queue_unit.sv =====
// Channel   Dir  tdata (low bit up)                 tuser        tlast
// s_axis    in   timeout_ms[31:0], handle[35:32]    cmd[1:0]     -
// m_axis    out  slot[3:0], nearest_timeout[35:4]   status[2:0]  last
//
// Every scan walks all SLOTS entries through the expiry memory read port.
// Delete, bad-timeout add and unused requests take one scan.
// Any other add takes two scans: one to find a free slot, one for the nearest timeout.
// A tick takes one scan, plus one more scan for each timer that fires.
// Reset clears the valid bits and the millisecond counter; no clearing pass is needed.
// A held result stalls the block only when the next result is ready to be loaded.
module deadline_timer_queue_unit #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 48
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // timeout_ms[31:0], handle[35:32], zero fill
  input  logic [dtq_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // slot[3:0], nearest_timeout[35:4], zero fill
  output logic [dtq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // status[2:0]
  output logic [2:0]                       m_axis_tuser,
  output logic                             m_axis_tlast
);

  dtq_pkg::dtq_cmd_t  ctl;
  dtq_pkg::dtq_stat_t stat;
  logic [3:0]         out_slot;
  logic [31:0]        out_near;
  logic               res_added;
  logic               res_full;
  logic               res_empty;
  logic               res_slot_ok;

  dtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  dtq_dpath #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_cmd_i      (s_axis_tuser),
    .in_timeout_i  (signed'(s_axis_tdata[31:0])),
    .in_handle_i   (s_axis_tdata[35:32]),
    .ctl_i         (ctl),
    .stat_o        (stat),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_status_o  (m_axis_tuser),
    .out_slot_o    (out_slot),
    .out_nearest_o (out_near),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, out_near, out_slot};

  assign res_added   = m_axis_tvalid && (m_axis_tuser == dtq_pkg::ST_ADDED);
  assign res_full    = m_axis_tvalid && (m_axis_tuser == dtq_pkg::ST_FULL);
  assign res_empty   = out_near == dtq_pkg::NEAR_EMPTY;
  assign res_slot_ok = (32'(out_slot) < SLOTS) || (m_axis_tuser == dtq_pkg::ST_NOTPEND);

`include "assert_macros.svh"

  `DTQ_ASSERT_IMPL(a_added_not_empty, res_added, !res_empty, "Added timer but empty table.")
  `DTQ_ASSERT_IMPL(a_full_not_empty, res_full, !res_empty, "Table full but reported empty.")
  `DTQ_ASSERT_IMPL(a_idle_last, m_axis_tvalid && s_axis_tready, m_axis_tlast, "Early request.")
  `DTQ_ASSERT(a_slot_range, !m_axis_tvalid || res_slot_ok, "Result slot outside the table.")

endmodule

// ===== hdl/dtq_dpath.sv =====
module dtq_dpath #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         in_cmd_i,
  input  logic signed [31:0] in_timeout_i,
  input  logic [3:0]         in_handle_i,
  input  dtq_pkg::dtq_cmd_t  ctl_i,
  output dtq_pkg::dtq_stat_t stat_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         out_status_o,
  output logic [3:0]         out_slot_o,
  output logic [31:0]        out_nearest_o,
  output logic               out_last_o
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

  logic [1:0]           cmd_q;
  logic [31:0]          tmo_q;
  logic [3:0]           handle_q;
  logic [TIME_BITS-1:0] now_q;
  logic [SLOTS-1:0]     valid_q;
  logic [TIME_BITS-1:0] exp_mem [SLOTS];

  logic                 act_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 s1_vld_q;
  logic [IDX_W-1:0]     s1_idx_q;
  logic                 s1_used_q;
  logic [TIME_BITS-1:0] rdata_q;

  logic                 free_found_q;
  logic [IDX_W-1:0]     free_idx_q;
  logic [CNT_W-1:0]     due_cnt_q;
  logic                 due_found_q;
  logic [TIME_BITS-1:0] due_best_q;
  logic [IDX_W-1:0]     due_idx_q;
  logic                 fut_found_q;
  logic [TIME_BITS-1:0] fut_best_q;

  logic [CNT_W-1:0]     fires_q;
  logic [31:0]          nearest_q;
  logic [2:0]           res_status_q;
  logic [3:0]           res_slot_q;
  logic                 res_last_q;

  logic                 out_vld_q;
  logic [2:0]           out_status_q;
  logic [3:0]           out_slot_q;
  logic [31:0]          out_near_q;
  logic                 out_last_q;

  logic                 issue;
  logic                 done;
  logic [IDX_W-1:0]     rd_idx;
  logic                 e_due;
  logic                 hdl_ok;
  logic [IDX_W-1:0]     hidx;
  logic [TIME_BITS-1:0] diff;
  logic [31:0]          near_d;
  logic [3:0]           slot_d;

  assign issue  = act_q && (cnt_q != SLOTS_C);
  assign done   = act_q && (cnt_q == SLOTS_C) && !s1_vld_q;
  assign rd_idx = cnt_q[IDX_W-1:0];
  assign e_due  = rdata_q <= now_q;
  assign hdl_ok = 32'(handle_q) < SLOTS;
  assign hidx   = IDX_W'(handle_q);
  assign diff   = fut_best_q - now_q;

  always_comb begin
    if ((cmd_q != dtq_pkg::CMD_TICK) && due_found_q) begin
      near_d = '0;
    end else if (fut_found_q) begin
      if (((diff >> 32) != '0) || (diff[31:0] == dtq_pkg::NEAR_EMPTY)) begin
        near_d = dtq_pkg::NEAR_MAX;
      end else begin
        near_d = diff[31:0];
      end
    end else begin
      near_d = dtq_pkg::NEAR_EMPTY;
    end
  end

  always_comb begin
    case (ctl_i.res_slot)
      dtq_pkg::SLOT_FREE:   slot_d = 4'(free_idx_q);
      dtq_pkg::SLOT_HANDLE: slot_d = handle_q;
      dtq_pkg::SLOT_PICK:   slot_d = 4'(due_idx_q);
      default:              slot_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.take_in) begin
      cmd_q    <= in_cmd_i;
      tmo_q    <= unsigned'(in_timeout_i);
      handle_q <= in_handle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q <= '0;
    end else if (ctl_i.tick) begin
      now_q <= now_q + TIME_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ctl_i.add_write) begin
        valid_q[free_idx_q] <= 1'b1;
      end
      if (ctl_i.del_clear) begin
        valid_q[hidx] <= 1'b0;
      end
      if (ctl_i.fire_clear) begin
        valid_q[due_idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.add_write) begin
      exp_mem[free_idx_q] <= now_q + TIME_BITS'(tmo_q);
    end
    if (issue) begin
      rdata_q <= exp_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= 1'b0;
      cnt_q    <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= issue && !ctl_i.scan_start;
      if (ctl_i.scan_start) begin
        act_q <= 1'b1;
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (done) begin
        act_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q  <= rd_idx;
    s1_used_q <= valid_q[rd_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_found_q <= 1'b0;
      due_found_q  <= 1'b0;
      fut_found_q  <= 1'b0;
      due_cnt_q    <= '0;
    end else if (ctl_i.scan_start) begin
      free_found_q <= 1'b0;
      due_found_q  <= 1'b0;
      fut_found_q  <= 1'b0;
      due_cnt_q    <= '0;
    end else if (s1_vld_q) begin
      if (!s1_used_q && !free_found_q) begin
        free_found_q <= 1'b1;
      end
      if (s1_used_q && e_due) begin
        due_cnt_q   <= due_cnt_q + CNT_W'(1);
        due_found_q <= 1'b1;
      end
      if (s1_used_q && !e_due) begin
        fut_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      if (!s1_used_q && !free_found_q) begin
        free_idx_q <= s1_idx_q;
      end
      if (s1_used_q && e_due && (!due_found_q || (rdata_q < due_best_q))) begin
        due_best_q <= rdata_q;
        due_idx_q  <= s1_idx_q;
      end
      if (s1_used_q && !e_due && (!fut_found_q || (rdata_q < fut_best_q))) begin
        fut_best_q <= rdata_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fires_q <= '0;
    end else if (ctl_i.load_fires) begin
      fires_q <= due_cnt_q;
    end else if (ctl_i.fire_clear) begin
      fires_q <= fires_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.calc_near) begin
      nearest_q <= near_d;
    end
    if (ctl_i.set_res) begin
      res_status_q <= ctl_i.res_status;
      res_slot_q   <= slot_d;
      res_last_q   <= ctl_i.res_pick_last ? (fires_q == CNT_W'(1)) : 1'b1;
    end
    if (ctl_i.emit) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_near_q   <= nearest_q;
      out_last_q   <= res_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctl_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign stat_o.cmd         = cmd_q;
  assign stat_o.bad_time    = (tmo_q == '0) || tmo_q[31];
  assign stat_o.hdl_pending = hdl_ok && valid_q[hidx];
  assign stat_o.scan_done   = done;
  assign stat_o.free_found  = free_found_q;
  assign stat_o.due_any     = due_cnt_q != '0;
  assign stat_o.fires_left  = fires_q != '0;
  assign stat_o.out_free    = !out_vld_q || out_ready_i;

  assign out_valid_o   = out_vld_q;
  assign out_status_o  = out_status_q;
  assign out_slot_o    = out_slot_q;
  assign out_nearest_o = out_near_q;
  assign out_last_o    = out_last_q;

endmodule

// ===== hdl/dtq_ctrl.sv =====
module dtq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dtq_pkg::dtq_stat_t stat_i,
  output dtq_pkg::dtq_cmd_t  ctl_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_FREE   = 3'd2;
  localparam logic [2:0] S_NEAR   = 3'd3;
  localparam logic [2:0] S_PICK   = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    ctl_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.take_in = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl_o.set_res    = 1'b1;
        ctl_o.scan_start = 1'b1;
        ctl_o.res_status = dtq_pkg::ST_NONE;
        ctl_o.res_slot   = dtq_pkg::SLOT_ZERO;
        state_d          = S_NEAR;
        case (stat_i.cmd)
          dtq_pkg::CMD_ADD: begin
            if (stat_i.bad_time) begin
              ctl_o.res_status = dtq_pkg::ST_BADTIME;
            end else begin
              ctl_o.set_res = 1'b0;
              state_d       = S_FREE;
            end
          end
          dtq_pkg::CMD_DEL: begin
            ctl_o.res_slot = dtq_pkg::SLOT_HANDLE;
            if (stat_i.hdl_pending) begin
              ctl_o.del_clear  = 1'b1;
              ctl_o.res_status = dtq_pkg::ST_DELETED;
            end else begin
              ctl_o.res_status = dtq_pkg::ST_NOTPEND;
            end
          end
          dtq_pkg::CMD_TICK: begin
            ctl_o.tick = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_FREE: begin
        if (stat_i.scan_done) begin
          ctl_o.set_res    = 1'b1;
          ctl_o.scan_start = 1'b1;
          state_d          = S_NEAR;
          if (stat_i.free_found) begin
            ctl_o.add_write  = 1'b1;
            ctl_o.res_status = dtq_pkg::ST_ADDED;
            ctl_o.res_slot   = dtq_pkg::SLOT_FREE;
          end else begin
            ctl_o.res_status = dtq_pkg::ST_FULL;
            ctl_o.res_slot   = dtq_pkg::SLOT_ZERO;
          end
        end
      end
      S_NEAR: begin
        if (stat_i.scan_done) begin
          ctl_o.calc_near = 1'b1;
          if ((stat_i.cmd == dtq_pkg::CMD_TICK) && stat_i.due_any) begin
            ctl_o.load_fires = 1'b1;
            ctl_o.scan_start = 1'b1;
            state_d          = S_PICK;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_PICK: begin
        if (stat_i.scan_done) begin
          ctl_o.fire_clear    = 1'b1;
          ctl_o.set_res       = 1'b1;
          ctl_o.res_status    = dtq_pkg::ST_FIRED;
          ctl_o.res_slot      = dtq_pkg::SLOT_PICK;
          ctl_o.res_pick_last = 1'b1;
          state_d             = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          ctl_o.emit = 1'b1;
          if (stat_i.fires_left) begin
            ctl_o.scan_start = 1'b1;
            state_d          = S_PICK;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== test/deadline_timer_queue_checker.sv =====
module deadline_timer_queue_checker #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [dtq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [1:0]                     s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [dtq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic [2:0]                     m_axis_tuser,
  input  logic                           m_axis_tlast,
  output int                             fail_count,
  output int                             outstanding,
  output int                             results_checked,
  output int                             timers_fired,
  output int                             full_rejects
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [31:0] nearest;
    logic        last;
  } timer_result_t;

  logic                 armed [SLOTS];
  logic [TIME_BITS-1:0] expiry [SLOTS];
  logic [TIME_BITS-1:0] clock_ms;
  timer_result_t        expected_q[$];

  function automatic timer_result_t make_result(logic [2:0] status, logic [3:0] slot);
    timer_result_t r;
    r.status  = status;
    r.slot    = slot;
    r.nearest = '0;
    r.last    = 1'b0;
    return r;
  endfunction

  function automatic logic [31:0] time_to_nearest();
    logic                 found;
    logic [TIME_BITS-1:0] best;
    logic [TIME_BITS-1:0] gap;
    found = 1'b0;
    best  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (armed[i] && (!found || expiry[i] < best)) begin
        best  = expiry[i];
        found = 1'b1;
      end
    end
    if (!found) return dtq_pkg::NEAR_EMPTY;
    if (best <= clock_ms) return '0;
    gap = best - clock_ms;
    if (gap > dtq_pkg::NEAR_MAX) return dtq_pkg::NEAR_MAX;
    return gap[31:0];
  endfunction

  task automatic apply_request(input logic [1:0] cmd, input logic [31:0] timeout,
                               input logic [3:0] handle);
    timer_result_t batch[$];
    int            free_slot;
    int            pick;
    logic [31:0]   nearest;
    case (cmd)
      dtq_pkg::CMD_ADD: begin
        free_slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!armed[i]) free_slot = i;
        end
        if (timeout == '0 || timeout[31]) begin
          batch.push_back(make_result(dtq_pkg::ST_BADTIME, 4'd0));
        end else if (free_slot < 0) begin
          batch.push_back(make_result(dtq_pkg::ST_FULL, 4'd0));
        end else begin
          armed[free_slot]  = 1'b1;
          expiry[free_slot] = clock_ms + TIME_BITS'(timeout);
          batch.push_back(make_result(dtq_pkg::ST_ADDED, 4'(free_slot)));
        end
      end
      dtq_pkg::CMD_DEL: begin
        if (armed[handle]) begin
          armed[handle] = 1'b0;
          batch.push_back(make_result(dtq_pkg::ST_DELETED, handle));
        end else begin
          batch.push_back(make_result(dtq_pkg::ST_NOTPEND, handle));
        end
      end
      dtq_pkg::CMD_TICK: begin
        clock_ms = clock_ms + 1'b1;
        do begin
          pick = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (armed[i] && expiry[i] <= clock_ms && (pick < 0 || expiry[i] < expiry[pick]))
              pick = i;
          end
          if (pick >= 0) begin
            armed[pick] = 1'b0;
            batch.push_back(make_result(dtq_pkg::ST_FIRED, 4'(pick)));
          end
        end while (pick >= 0);
        if (batch.size() == 0) batch.push_back(make_result(dtq_pkg::ST_NONE, 4'd0));
      end
      default: begin
        batch.push_back(make_result(dtq_pkg::ST_NONE, 4'd0));
      end
    endcase
    nearest = time_to_nearest();
    foreach (batch[k]) batch[k].nearest = nearest;
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) expected_q.push_back(batch[k]);
  endtask

  task automatic note_failure(input string what, input timer_result_t want,
                              input timer_result_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%t %s: expected status %0d slot %0d nearest %h last %b",
               $realtime, what, want.status, want.slot, want.nearest, want.last);
      $display("%t %s: got status %0d slot %0d nearest %h last %b",
               $realtime, what, got.status, got.slot, got.nearest, got.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    timer_result_t got;
    timer_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) armed[i] = 1'b0;
      clock_ms = '0;
      expected_q.delete();
      fail_count      = 0;
      outstanding     = 0;
      results_checked = 0;
      timers_fired    = 0;
      full_rejects    = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        apply_request(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[35:32]);
      if (m_axis_tvalid && m_axis_tready) begin
        got.status  = m_axis_tuser;
        got.slot    = m_axis_tdata[3:0];
        got.nearest = m_axis_tdata[35:4];
        got.last    = m_axis_tlast;
        results_checked++;
        if (got.status == dtq_pkg::ST_FIRED) timers_fired++;
        if (got.status == dtq_pkg::ST_FULL) full_rejects++;
        if (expected_q.size() == 0) begin
          note_failure("unexpected result", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status || got.slot !== want.slot ||
              got.nearest !== want.nearest || got.last !== want.last)
            note_failure("result mismatch", want, got);
        end
      end
      outstanding = expected_q.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         SLOTS        = 16;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         QUIET_LIMIT  = 5000;
  localparam int         DRAIN_CYCLES = 100;
  localparam int         PHASE_ITEMS  = 87;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [dtq_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic [1:0]                     s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [dtq_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [2:0]                     m_axis_tuser;
  logic                           m_axis_tlast;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int requests_sent  = 0;
  int quiet_cycles   = 0;
  int fail_count;
  int outstanding;
  int results_checked;
  int timers_fired;
  int full_rejects;

  always #10 clk_i = ~clk_i;

  deadline_timer_queue_unit #(
    .SLOTS(SLOTS),
    .TIME_BITS(48)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  deadline_timer_queue_checker #(
    .SLOTS(SLOTS),
    .TIME_BITS(48)
  ) timer_checker (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .fail_count(fail_count),
    .outstanding(outstanding),
    .results_checked(results_checked),
    .timers_fired(timers_fired),
    .full_rejects(full_rejects)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timed out with %0d results still outstanding.", outstanding);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [1:0] cmd, input logic [31:0] timeout,
                              input logic [3:0] handle);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'b0000, handle, timeout};
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
  endtask

  task automatic random_request(output logic [1:0] cmd);
    int          pick;
    logic [31:0] timeout;
    logic [3:0]  handle;
    pick    = $urandom_range(99);
    timeout = $urandom();
    handle  = 4'($urandom_range(SLOTS - 1));
    if (pick < 38) begin
      cmd = dtq_pkg::CMD_TICK;
    end else if (pick < 66) begin
      cmd     = dtq_pkg::CMD_ADD;
      timeout = $urandom_range(24, 1);
    end else if (pick < 70) begin
      cmd     = dtq_pkg::CMD_ADD;
      timeout = $urandom_range(5000, 25);
    end else if (pick < 84) begin
      cmd = dtq_pkg::CMD_DEL;
    end else if (pick < 92) begin
      cmd = dtq_pkg::CMD_ADD;
    end else if (pick < 95) begin
      cmd     = dtq_pkg::CMD_ADD;
      timeout = '0;
    end else begin
      cmd = CMD_UNUSED;
    end
    send_request(cmd, timeout, handle);
  endtask

  initial begin
    logic [1:0] cmd;
    int         counted;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= dtq_pkg::CMD_ADD;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(dtq_pkg::CMD_ADD, 32'd1, 4'd0);
    send_request(dtq_pkg::CMD_ADD, 32'd0, 4'd0);
    send_request(dtq_pkg::CMD_ADD, 32'hFFFF_FFFF, 4'hF);
    send_request(dtq_pkg::CMD_ADD, 32'h7FFF_FFFF, 4'd0);
    send_request(dtq_pkg::CMD_DEL, 32'd0, 4'd1);
    send_request(dtq_pkg::CMD_DEL, 32'hFFFF_FFFF, 4'd15);
    send_request(dtq_pkg::CMD_TICK, 32'd0, 4'd0);
    send_request(CMD_UNUSED, 32'hA5A5_5A5A, 4'hA);
    for (int i = 0; i < SLOTS; i++) send_request(dtq_pkg::CMD_ADD, 32'd2, 4'(i));
    send_request(dtq_pkg::CMD_ADD, 32'd5, 4'd0);
    send_request(dtq_pkg::CMD_TICK, 32'd0, 4'd0);
    send_request(dtq_pkg::CMD_TICK, 32'd0, 4'd0);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: begin
          send_idle_pct  = 81;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 81;
        end
        3: begin
          send_idle_pct  = 18;
          recv_stall_pct = 18;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        random_request(cmd);
        if (cmd != CMD_UNUSED) counted++;
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);

    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d requests and %0d checked results: %0d timers fired,",
             requests_sent, results_checked, timers_fired);
    $display("%0d adds refused on a full table, %0d failures counted.",
             full_rejects, fail_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
